FILE: rtl/pop3p_pkg.sv
package pop3p_pkg;

	// Character codes used by the line recognizer.
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CH_PRINT_LO = 8'h21;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;

	// Number of command bytes visible in the command word.
	localparam int unsigned CMD_SLOTS = 4;

	typedef enum logic [3:0] {
		ST_START   = 4'd0,
		ST_C1      = 4'd1,
		ST_C2      = 4'd2,
		ST_C3      = 4'd3,
		ST_C4      = 4'd4,
		ST_ARG     = 4'd5,
		ST_CR_SEEN = 4'd6,
		ST_END     = 4'd7,
		ST_ERR     = 4'd8
	} line_state_t;

	typedef enum logic [1:0] {
		STAT_READING  = 2'd0,
		STAT_ERROR    = 2'd1,
		STAT_FINISHED = 2'd2
	} stat_t;

	// Result of one byte, as handed from the recognizer to the output register.
	typedef struct packed {
		stat_t        status;
		logic [31:0]  command_word;
		logic [2:0]   command_count;
		logic         arg_valid;
		logic [7:0]   arg_byte;
		logic [5:0]   arg_position;
		logic [6:0]   arg_count;
	} result_t;

endpackage

FILE: rtl/pop3p_in_if.sv
interface pop3p_in_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic [7:0] in_byte;

	modport source (output valid, output restart, output in_byte, input ready);
	modport sink (input valid, input restart, input in_byte, output ready);
endinterface

FILE: rtl/pop3p_out_if.sv
interface pop3p_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] command_word;
	logic [2:0]  command_count;
	logic        arg_valid;
	logic [7:0]  arg_byte;
	logic [5:0]  arg_position;
	logic [6:0]  arg_count;

	modport source (output valid, output status, output command_word, output command_count,
		output arg_valid, output arg_byte, output arg_position, output arg_count,
		input ready);
	modport sink (input valid, input status, input command_word, input command_count,
		input arg_valid, input arg_byte, input arg_position, input arg_count,
		output ready);
endinterface

FILE: rtl/pop3p_fsm.sv
module pop3p_fsm #(
	parameter int unsigned CMD_CHARS = 4,
	parameter int unsigned ARG_MAX   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               restart,
	input  logic [7:0]         in_byte,
	output pop3p_pkg::result_t res
);
	import pop3p_pkg::*;

	localparam int unsigned AL_W      = $clog2(ARG_MAX + 1);
	localparam logic [3:0]  CMD_LIMIT = 4'(CMD_CHARS);
	localparam logic [AL_W-1:0] ARG_LIMIT = AL_W'(ARG_MAX);

	line_state_t     state_q;
	logic [31:0]     word_q;
	logic [2:0]      cmd_len_q;
	logic [AL_W-1:0] arg_len_q;

	line_state_t     state_cur;
	line_state_t     state_nxt;
	logic [31:0]     word_cur;
	logic [31:0]     word_nxt;
	logic [2:0]      cmd_len_cur;
	logic [2:0]      cmd_len_nxt;
	logic [AL_W-1:0] arg_len_cur;
	logic [AL_W-1:0] arg_len_nxt;
	logic [31:0]     arg_cur_wide;
	logic [31:0]     arg_nxt_wide;

	logic  is_alpha;
	logic  is_print;
	logic  is_cr;
	logic  is_lf;
	logic  is_blank;
	logic  cmd_room;
	logic  arg_room;
	logic  store_cmd;
	logic  take_arg;
	stat_t status;

	// A restart clears everything before the byte is looked at.
	assign state_cur   = restart ? ST_START : state_q;
	assign word_cur    = restart ? '0 : word_q;
	assign cmd_len_cur = restart ? '0 : cmd_len_q;
	assign arg_len_cur = restart ? '0 : arg_len_q;

	// Byte classes.
	assign is_alpha  = !in_byte[7] && ((in_byte | CH_SPACE) >= CH_LOWER_A)
		&& ((in_byte | CH_SPACE) <= CH_LOWER_Z);
	assign is_print  = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI);
	assign is_cr     = (in_byte == CH_CR);
	assign is_lf     = (in_byte == CH_LF);
	assign is_blank  = (in_byte == CH_SPACE);
	assign cmd_room  = ({1'b0, cmd_len_cur} < CMD_LIMIT);
	assign arg_room  = (arg_len_cur < ARG_LIMIT);

	// Next state.
	always_comb begin
		case (state_cur)
			ST_START: begin
				state_nxt = is_alpha ? ST_C1 : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_C1: begin
				state_nxt = is_alpha ? ST_C2 : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_C2: begin
				state_nxt = is_alpha ? ST_C3 : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_C3: begin
				state_nxt = is_alpha ? ST_C4 : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_C4: begin
				state_nxt = is_blank ? ST_ARG : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_ARG: begin
				state_nxt = is_print ? ST_ARG : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_CR_SEEN: begin
				state_nxt = is_lf ? ST_END : (is_cr ? ST_CR_SEEN : ST_ERR);
			end
			ST_END: begin
				state_nxt = ST_END;
			end
			default: begin
				state_nxt = is_cr ? ST_CR_SEEN : ST_ERR;
			end
		endcase
	end

	// Status and the two store strobes.
	always_comb begin
		status    = STAT_ERROR;
		store_cmd = 1'b0;
		take_arg  = 1'b0;
		case (state_cur)
			ST_START, ST_C1, ST_C2, ST_C3: begin
				if (is_alpha && cmd_room) begin
					status    = STAT_READING;
					store_cmd = 1'b1;
				end
			end
			ST_C4: begin
				if (is_blank || is_cr) begin
					status = STAT_READING;
				end
			end
			ST_ARG: begin
				if (is_print) begin
					if (arg_room) begin
						status   = STAT_READING;
						take_arg = 1'b1;
					end
				end else if (is_cr) begin
					status = STAT_READING;
				end
			end
			ST_CR_SEEN: begin
				if (is_lf) begin
					status = STAT_FINISHED;
				end
			end
			ST_END: begin
				status = STAT_READING;
			end
			default: begin
				status = STAT_ERROR;
			end
		endcase
	end

	// Command byte goes into the slot given by the current length.
	always_comb begin
		word_nxt = word_cur;
		for (int i = 0; i < CMD_SLOTS; i++) begin
			if (store_cmd && (cmd_len_cur[1:0] == 2'(i))) begin
				word_nxt[8*i +: 8] = in_byte;
			end
		end
	end

	assign cmd_len_nxt  = cmd_len_cur + {2'b00, store_cmd};
	assign arg_len_nxt  = arg_len_cur + AL_W'(take_arg);
	assign arg_cur_wide = 32'(arg_len_cur);
	assign arg_nxt_wide = 32'(arg_len_nxt);

	// Result of this byte, taken after the update.
	always_comb begin
		res.status        = status;
		res.command_word  = word_nxt;
		res.command_count = cmd_len_nxt;
		res.arg_valid     = take_arg;
		res.arg_byte      = take_arg ? in_byte : 8'h00;
		res.arg_position  = take_arg ? arg_cur_wide[5:0] : 6'd0;
		res.arg_count     = arg_nxt_wide[6:0];
	end

	// Parser state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_START;
			word_q    <= '0;
			cmd_len_q <= '0;
			arg_len_q <= '0;
		end else if (step) begin
			state_q   <= state_nxt;
			word_q    <= word_nxt;
			cmd_len_q <= cmd_len_nxt;
			arg_len_q <= arg_len_nxt;
		end
	end

endmodule

FILE: rtl/pop3_command_line_parser.sv
// Channel      Modport  Payload
// byte_stream  sink     restart, in_byte
// result       source   status, command_word, command_count, arg_valid,
//                       arg_byte, arg_position, arg_count
//
// One byte per cycle unless a held result is not taken; each result appears in the cycle after its byte is taken.
// The state update and the result are computed in the same cycle from the
// incoming byte and the parser registers, then held in one output register.
// A new byte is taken while the held result is being drained; only a result
// that is not taken stalls the input.
// Reset returns the parser to the start state with empty command and argument.
module pop3_command_line_parser #(
	parameter int unsigned CMD_CHARS = 4,
	parameter int unsigned ARG_MAX   = 64
) (
	input logic         clk,
	input logic         arst_n,
	pop3p_in_if.sink    byte_stream,
	pop3p_out_if.source result
);
	import pop3p_pkg::*;

	logic    accept;
	logic    res_valid_q;
	result_t res_q;
	result_t step_res;

	assign byte_stream.ready = !res_valid_q || result.ready;
	assign accept            = byte_stream.valid && byte_stream.ready;

	pop3p_fsm #(
		.CMD_CHARS (CMD_CHARS),
		.ARG_MAX   (ARG_MAX)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.restart (byte_stream.restart),
		.in_byte (byte_stream.in_byte),
		.res     (step_res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= step_res;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = res_q.status;
	assign result.command_word  = res_q.command_word;
	assign result.command_count = res_q.command_count;
	assign result.arg_valid     = res_q.arg_valid;
	assign result.arg_byte      = res_q.arg_byte;
	assign result.arg_position  = res_q.arg_position;
	assign result.arg_count     = res_q.arg_count;

	// A held result that is not taken must block the next transaction.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !accept)
		else $error("input accepted while output register is stalled");

	// A captured argument byte is always counted right after its position.
	a_arg_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.arg_valid) |->
		(result.arg_count[5:0] == result.arg_position + 6'd1))
		else $error("argument count does not follow argument position");

	// Argument capture only happens on a byte that reads cleanly.
	a_arg_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.arg_valid) |-> (result.status == STAT_READING))
		else $error("argument byte captured with non-reading status");

	// At most four command letters are ever stored.
	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.command_count <= 3'd4))
		else $error("command count out of range");

	// An accepted byte always produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted byte produced no result");

endmodule
